// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the registry table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/krt_pkg.sv =====
// Types and codes of the keyed registry table.
package krt_pkg;

    localparam int CLIENT_CAP = 200;

    localparam logic [1:0] OP_JOIN  = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_JOIN_ERR  = 3'd1;
    localparam logic [2:0] ST_LEAVE_ERR = 3'd2;
    localparam logic [2:0] ST_QUERY_ERR = 3'd3;
    localparam logic [2:0] ST_CMD_ERR   = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] address;
        logic [15:0] port;
    } entry_t;

endpackage

// ===== rtl/core/krt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/keyed_registry_table_unit.sv =====
// Top level of the keyed registry table: request scan, update and result register.
// A request is taken in the idle state and no new one is taken until it is done: the
// scan reads the whole table, slot by slot, through the single registered read port of
// the entry RAM; the finish state then writes back and loads the result once the result
// register is free. The result register lets the next request be taken while a result
// still waits. After reset a clearing pass writes every slot before the first request
// is taken. Keys are compared after cutting them to KEY_BYTES bytes and zeroing every
// byte after the first zero byte.
`include "assert_macros.svh"
module keyed_registry_table_unit #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // name_key[63:0], peer_address[95:64], peer_port[111:96]
    input  logic [1:0]   s_tuser,  // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // found_address[31:0], found_port[47:32]
    output logic [2:0]   m_tuser   // status[2:0]
);

    import krt_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int USABLE = (TABLE_SLOTS < CLIENT_CAP) ? TABLE_SLOTS : CLIENT_CAP;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
    localparam logic [IW:0] USABLE_W = (IW + 1)'(USABLE);
    localparam int EW = $bits(entry_t);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [1:0]    op_reg, op_next;
    logic [63:0]   key_reg, key_next;
    logic [31:0]   addr_reg, addr_next;
    logic [15:0]   port_reg, port_next;
    logic [IW-1:0] issue_reg, issue_next;
    logic          issuing_reg, issuing_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]   hit_addr_reg, hit_addr_next;
    logic [15:0]   hit_port_reg, hit_port_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [31:0]   m_addr_reg, m_addr_next;
    logic [15:0]   m_port_reg, m_port_next;

    logic [63:0]   key_norm;
    logic          alive;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [EW-1:0] ram_rdata;
    entry_t        rd_entry;
    entry_t        wr_entry;
    logic          out_load;

    logic [2:0]    res_status;
    logic [31:0]   res_addr;
    logic [15:0]   res_port;
    logic          res_we;
    logic [IW-1:0] res_waddr;
    entry_t        res_entry;

    krt_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_SLOTS)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(issue_reg),
        .rdata(ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign wr_entry = entry_t'(ram_wdata);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_port_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

    always_comb
    begin
        alive    = 1'b1;
        key_norm = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b >= KEY_BYTES || s_tdata[63-8*b -: 8] == 8'h00)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                key_norm[63-8*b -: 8] = s_tdata[63-8*b -: 8];
            end
        end
    end

    always_comb
    begin
        res_status = ST_CMD_ERR;
        res_addr   = '0;
        res_port   = '0;
        res_we     = 1'b0;
        res_waddr  = free_idx_reg;
        res_entry  = '{valid: 1'b1, key: key_reg, address: addr_reg, port: port_reg};
        case (op_reg)
            OP_JOIN:
            begin
                if (!hit_reg && free_reg)
                begin
                    res_status = ST_OK;
                    res_we     = 1'b1;
                end
                else
                begin
                    res_status = ST_JOIN_ERR;
                end
            end
            OP_LEAVE:
            begin
                res_waddr = hit_idx_reg;
                res_entry = '{valid: 1'b0, key: key_reg, address: hit_addr_reg,
                              port: hit_port_reg};
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    res_we     = 1'b1;
                end
                else
                begin
                    res_status = ST_LEAVE_ERR;
                end
            end
            OP_QUERY:
            begin
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    res_addr   = hit_addr_reg;
                    res_port   = hit_port_reg;
                end
                else
                begin
                    res_status = ST_QUERY_ERR;
                end
            end
            default:
            begin
                res_status = ST_CMD_ERR;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        addr_next     = addr_reg;
        port_next     = port_reg;
        issue_next    = issue_reg;
        issuing_next  = issuing_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = issue_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_addr_next = hit_addr_reg;
        hit_port_next = hit_port_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        m_port_next   = m_port_reg;
        ram_we        = 1'b0;
        ram_waddr     = res_waddr;
        ram_wdata     = EW'(res_entry);
        ram_re        = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = s_tuser;
                    key_next     = key_norm;
                    addr_next    = s_tdata[95:64];
                    port_next    = s_tdata[111:96];
                    issue_next   = '0;
                    issuing_next = 1'b1;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_valid_next = issuing_reg;
                if (issuing_reg)
                begin
                    ram_re     = 1'b1;
                    issue_next = issue_reg + 1'b1;
                    if (issue_reg == LAST_IDX)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (rd_valid_reg)
                begin
                    if (rd_entry.valid && rd_entry.key == key_reg && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = rd_idx_reg;
                        hit_addr_next = rd_entry.address;
                        hit_port_next = rd_entry.port;
                    end
                    if (!rd_entry.valid && {1'b0, rd_idx_reg} < USABLE_W && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    ram_we        = res_we;
                    m_valid_next  = 1'b1;
                    m_status_next = res_status;
                    m_addr_next   = res_addr;
                    m_port_next   = res_port;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            issuing_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            issuing_reg  <= issuing_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        port_reg     <= port_next;
        issue_reg    <= issue_next;
        rd_idx_reg   <= rd_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_addr_reg <= hit_addr_next;
        hit_port_reg <= hit_port_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
        m_port_reg   <= m_port_next;
    end

    `ASSERT_ALWAYS(a_no_rw_overlap, clk, rst_n, !(ram_we && ram_re), "RAM read and write overlap")
    `ASSERT_IMPLY(a_result_from_finish, clk, rst_n, $rose(m_valid_reg),
        $past(state_reg) == S_FINISH, "result loaded outside finish")
    `ASSERT_IMPLY(a_join_writes, clk, rst_n,
        out_load && op_reg == OP_JOIN && res_status == ST_OK, ram_we && wr_entry.valid,
        "join ok without entry write")
    `ASSERT_IMPLY(a_miss_zero, clk, rst_n, m_tvalid && m_tuser != ST_OK, m_tdata == '0,
        "nonzero endpoint on error")

endmodule
